// ===== sv/assert_macros.svh =====
// Assertion helpers: hold a property under clock and asynchronous active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/fdss_pkg.sv =====
`default_nettype none
package fdss_pkg;
	localparam int VALUE_W     = 16;
	localparam int DIGIT_W     = 4;
	localparam int POS_W       = 2;
	localparam int SEG_W       = 8;
	localparam int DOT_W       = 3;
	localparam int DIV10_SHIFT = 19;
	localparam logic [VALUE_W-1:0] DIV10_MUL = 16'hCCCD;
	localparam logic [DOT_W-1:0]   DOT_RESET = 3'd1;
	localparam int SEG_DP_BIT  = 7;

	function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	function automatic int unsigned pow10(input int n);
		int unsigned lim;
		lim = 1;
		for (int k = 0; k < n; k++) begin
			lim = lim * 10;
		end
		return lim;
	endfunction
endpackage
`default_nettype wire

// ===== sv/fdss_digit_cell.sv =====
`default_nettype none
module fdss_digit_cell #(
	parameter int NUM_DIGITS = 4,
	parameter int SLOT       = 0
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      valid_in,
	input  wire logic [fdss_pkg::VALUE_W-1:0]              quo_in,
	input  wire logic [NUM_DIGITS*fdss_pkg::DIGIT_W-1:0]   digs_in,
	output logic                                           valid_out,
	output logic [fdss_pkg::VALUE_W-1:0]                   quo_out,
	output logic [NUM_DIGITS*fdss_pkg::DIGIT_W-1:0]        digs_out
);
	logic [2*fdss_pkg::VALUE_W-1:0]               prod;
	logic [fdss_pkg::VALUE_W-1:0]                 quo_next;
	logic [fdss_pkg::VALUE_W-1:0]                 rem_full;
	logic [NUM_DIGITS*fdss_pkg::DIGIT_W-1:0]      digs_next;
	logic                                         valid_q;
	logic [fdss_pkg::VALUE_W-1:0]                 quo_q;
	logic [NUM_DIGITS*fdss_pkg::DIGIT_W-1:0]      digs_q;

	always_comb begin
		prod      = {{fdss_pkg::VALUE_W{1'b0}}, quo_in} *
			{{fdss_pkg::VALUE_W{1'b0}}, fdss_pkg::DIV10_MUL};
		quo_next  = fdss_pkg::VALUE_W'(prod >> fdss_pkg::DIV10_SHIFT);
		rem_full  = quo_in - ((quo_next << 3) + (quo_next << 1));
		digs_next = digs_in;
		digs_next[SLOT*fdss_pkg::DIGIT_W +: fdss_pkg::DIGIT_W] =
			rem_full[fdss_pkg::DIGIT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		quo_q  <= quo_next;
		digs_q <= digs_next;
	end

	assign valid_out = valid_q;
	assign quo_out   = quo_q;
	assign digs_out  = digs_q;
endmodule
`default_nettype wire

// ===== sv/fdss_scan_out.sv =====
`default_nettype none
module fdss_scan_out #(
	parameter int NUM_DIGITS = 4
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      load,
	input  wire logic [NUM_DIGITS*fdss_pkg::DIGIT_W-1:0]   digs_in,
	input  wire logic [fdss_pkg::DOT_W-1:0]                dot_pos,
	output logic                                           strobe,
	output logic [fdss_pkg::POS_W-1:0]                     digit_position,
	output logic [fdss_pkg::DIGIT_W-1:0]                   digit_value,
	output logic [fdss_pkg::SEG_W-1:0]                     segments,
	output logic                                           last_digit
);
	localparam int CNT_W = $clog2(NUM_DIGITS + 1);
	localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(NUM_DIGITS - 1);

	logic                                      active_q;
	logic [CNT_W-1:0]                          pos_q;
	logic [NUM_DIGITS*fdss_pkg::DIGIT_W-1:0]   digs_q;
	logic                                      at_last;
	logic [fdss_pkg::SEG_W-1:0]                seg_base;

	assign at_last = (pos_q == LAST_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= '0;
		end else begin
			priority if (load) begin
				active_q <= 1'b1;
				pos_q    <= '0;
			end else if (active_q) begin
				// advance, drop out after the final digit
				active_q <= !at_last;
				pos_q    <= at_last ? '0 : pos_q + CNT_W'(1);
			end else begin
				active_q <= active_q;
				pos_q    <= pos_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digs_q <= digs_in;
		end else if (active_q) begin
			digs_q <= digs_q >> fdss_pkg::DIGIT_W;
		end
	end

	always_comb begin
		digit_value = digs_q[fdss_pkg::DIGIT_W-1:0];
		seg_base    = fdss_pkg::seg_of(digit_value);
		segments    = seg_base;
		segments[fdss_pkg::SEG_DP_BIT] = seg_base[fdss_pkg::SEG_DP_BIT] |
			(int'(pos_q) == int'(dot_pos));
		strobe         = active_q;
		digit_position = fdss_pkg::POS_W'(pos_q);
		last_digit     = at_last;
	end
endmodule
`default_nettype wire

// ===== sv/four_digit_seven_segment_scan_unit.sv =====
// The first digit reaches the ports after the item passes the digit cells and is
// loaded into the output shifter; then one digit per cycle, NUM_DIGITS in all, for
// a value below 10**NUM_DIGITS (a larger value shows none). A new item is held off
// by busy until the output shifter is free; the receiver cannot stall.
// Reset: clears all valid flags and counters; dot position returns to 1.
`default_nettype none
`include "assert_macros.svh"
module four_digit_seven_segment_scan_unit #(
	parameter int NUM_DIGITS = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [fdss_pkg::VALUE_W-1:0]    value,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [fdss_pkg::DOT_W-1:0]      cfg_data,
	output logic                                 strobe,
	output logic [fdss_pkg::POS_W-1:0]           digit_position,
	output logic [fdss_pkg::DIGIT_W-1:0]         digit_value,
	output logic [fdss_pkg::SEG_W-1:0]           segments,
	output logic                                 last_digit
);
	localparam int CNT_W = $clog2(NUM_DIGITS + 1);
	localparam logic [31:0] LIMIT = 32'(fdss_pkg::pow10(NUM_DIGITS));
	localparam int DIGS_W = NUM_DIGITS * fdss_pkg::DIGIT_W;

	logic                            accept;
	logic                            in_range;
	logic [CNT_W-1:0]                gap_q;
	logic [fdss_pkg::DOT_W-1:0]      dot_q;
	logic                            valid_c [0:NUM_DIGITS];
	logic [fdss_pkg::VALUE_W-1:0]    quo_c   [0:NUM_DIGITS];
	logic [DIGS_W-1:0]               digs_c  [0:NUM_DIGITS];

	assign accept    = start && !busy;
	assign in_range  = ({16'd0, value} < LIMIT);
	assign busy      = (gap_q != '0);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
			dot_q <= fdss_pkg::DOT_RESET;
		end else begin
			// hold off the next item until the shifter is free
			if (accept) begin
				gap_q <= CNT_W'(NUM_DIGITS - 1);
			end else if (busy) begin
				gap_q <= gap_q - CNT_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				dot_q <= cfg_data;
			end
		end
	end

	assign valid_c[0] = accept && in_range;
	assign quo_c[0]   = value;
	assign digs_c[0]  = '0;

	for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
		fdss_digit_cell #(
			.NUM_DIGITS (NUM_DIGITS),
			.SLOT       (NUM_DIGITS - 1 - k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (valid_c[k]),
			.quo_in    (quo_c[k]),
			.digs_in   (digs_c[k]),
			.valid_out (valid_c[k+1]),
			.quo_out   (quo_c[k+1]),
			.digs_out  (digs_c[k+1])
		);
	end

	fdss_scan_out #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (valid_c[NUM_DIGITS]),
		.digs_in        (digs_c[NUM_DIGITS]),
		.dot_pos        (dot_q),
		.strobe         (strobe),
		.digit_position (digit_position),
		.digit_value    (digit_value),
		.segments       (segments),
		.last_digit     (last_digit)
	);

	`ASSERT_NEXT(a_run_unbroken, clk, arst_n, strobe && !last_digit, strobe)
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, accept && (NUM_DIGITS > 1), busy)
	`ASSERT_IMPLIES(a_digit_decimal, clk, arst_n, strobe, digit_value <= 4'd9)
	`ASSERT_IMPLIES(a_last_position, clk, arst_n, strobe && last_digit, digit_position == fdss_pkg::POS_W'(NUM_DIGITS - 1))
endmodule
`default_nettype wire

// ===== test/tb_four_digit_seven_segment_scan_unit.sv =====
`timescale 1ns / 100ps

module tb_four_digit_seven_segment_scan_unit;

	localparam int DIGITS = 4;
	localparam int unsigned SHOW_LIMIT = 10 ** DIGITS;
	localparam int SETTLE_CYCLES = 2 * DIGITS + 4;
	localparam logic [fdss_pkg::SEG_W-1:0] GLYPH [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};
	localparam logic [fdss_pkg::SEG_W-1:0] DOT_SEG = 8'h80;
	localparam logic [fdss_pkg::VALUE_W-1:0] DIRECTED [19] = '{
		16'd0, 16'd9999, 16'd10000, 16'hFFFF, 16'd1, 16'd10, 16'd100, 16'd1000,
		16'd1234, 16'd5678, 16'd9090, 16'd8888, 16'd4040, 16'd7531, 16'd2468,
		16'd3690, 16'd10001, 16'h5555, 16'd0
	};
	localparam logic [fdss_pkg::DOT_W-1:0] DOT_PLAN [8] = '{
		3'd0, 3'd3, 3'd4, 3'd7, 3'd2, 3'd5, 3'd6, 3'd1
	};

	typedef enum logic [1:0] {
		SHOW_VALUE,
		SET_DOT,
		WAIT_IDLE
	} stim_kind_t;

	typedef struct {
		stim_kind_t kind;
		logic [fdss_pkg::VALUE_W-1:0] data;
		int gap;
	} stim_item_t;

	typedef struct {
		logic [fdss_pkg::POS_W-1:0] pos;
		logic [fdss_pkg::DIGIT_W-1:0] digit;
		logic [fdss_pkg::SEG_W-1:0] seg;
		logic last;
	} digit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [fdss_pkg::VALUE_W-1:0] value = '0;
	logic cfg_valid = 1'b0;
	logic [fdss_pkg::DOT_W-1:0] cfg_data = '0;
	logic busy;
	logic cfg_ready;
	logic strobe;
	logic [fdss_pkg::POS_W-1:0] digit_position;
	logic [fdss_pkg::DIGIT_W-1:0] digit_value;
	logic [fdss_pkg::SEG_W-1:0] segments;
	logic last_digit;

	stim_item_t pending_items[$];
	digit_t expected_digits[$];
	digit_t want;
	logic [fdss_pkg::DOT_W-1:0] dot_pos = fdss_pkg::DOT_RESET;
	bit value_taken = 1'b0;
	bit cfg_taken = 1'b0;
	bit stim_done = 1'b0;
	int gap_count = 0;
	int quiet_cycles = 0;
	int mismatches = 0;

	four_digit_seven_segment_scan_unit #(
		.NUM_DIGITS(DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.digit_position(digit_position),
		.digit_value(digit_value),
		.segments(segments),
		.last_digit(last_digit)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_error(input string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s", $time, what);
		end
	endtask

	task automatic split_into_digits(input logic [fdss_pkg::VALUE_W-1:0] v);
		int unsigned rest;
		logic [fdss_pkg::DIGIT_W-1:0] digs [DIGITS];
		digit_t d;
		if (v >= SHOW_LIMIT) begin
			return;
		end
		rest = 32'(v);
		for (int i = DIGITS - 1; i >= 0; i--) begin
			digs[i] = fdss_pkg::DIGIT_W'(rest % 10);
			rest = rest / 10;
		end
		for (int i = 0; i < DIGITS; i++) begin
			d.pos = i[fdss_pkg::POS_W-1:0];
			d.digit = digs[i];
			d.seg = GLYPH[digs[i]] | ((i == dot_pos) ? DOT_SEG : '0);
			d.last = (i == DIGITS - 1);
			expected_digits.push_back(d);
		end
	endtask

	task automatic queue_item(input stim_kind_t kind,
			input logic [fdss_pkg::VALUE_W-1:0] data, input int gap);
		stim_item_t it;
		it.kind = kind;
		it.data = data;
		it.gap = gap;
		pending_items.push_back(it);
	endtask

	always @(posedge clk) begin
		value_taken = arst_n && start && !busy;
		cfg_taken = arst_n && cfg_valid && cfg_ready;
		if (arst_n && strobe) begin
			if (expected_digits.size() == 0) begin
				flag_error($sformatf("digit with none expected: pos %0d value %0d seg %h last %b",
					digit_position, digit_value, segments, last_digit));
			end else begin
				want = expected_digits.pop_front();
				if (digit_position !== want.pos) begin
					flag_error($sformatf("digit_position: expected %0d, got %0d",
						want.pos, digit_position));
				end
				if (digit_value !== want.digit) begin
					flag_error($sformatf("digit_value at pos %0d: expected %0d, got %0d",
						want.pos, want.digit, digit_value));
				end
				if (segments !== want.seg) begin
					flag_error($sformatf("segments at pos %0d: expected %h, got %h",
						want.pos, want.seg, segments));
				end
				if (last_digit !== want.last) begin
					flag_error($sformatf("last_digit at pos %0d: expected %b, got %b",
						want.pos, want.last, last_digit));
				end
			end
		end
		if (cfg_taken) begin
			dot_pos = cfg_data;
		end
		if (value_taken) begin
			split_into_digits(value);
		end
		if (value_taken || strobe) begin
			quiet_cycles = 0;
		end else if (quiet_cycles < 1000) begin
			quiet_cycles++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(start && !value_taken) && !(cfg_valid && !cfg_taken)) begin
			if (pending_items.size() == 0) begin
				start <= 1'b0;
				cfg_valid <= 1'b0;
				stim_done <= 1'b1;
			end else if (gap_count < pending_items[0].gap) begin
				gap_count++;
				start <= 1'b0;
				cfg_valid <= 1'b0;
			end else begin
				case (pending_items[0].kind)
					SHOW_VALUE: begin
						start <= 1'b1;
						value <= pending_items[0].data;
						cfg_valid <= 1'b0;
						void'(pending_items.pop_front());
						gap_count = 0;
					end
					SET_DOT: begin
						start <= 1'b0;
						if (expected_digits.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
							cfg_valid <= 1'b1;
							cfg_data <= pending_items[0].data[fdss_pkg::DOT_W-1:0];
							void'(pending_items.pop_front());
							gap_count = 0;
						end else begin
							cfg_valid <= 1'b0;
						end
					end
					default: begin
						start <= 1'b0;
						cfg_valid <= 1'b0;
						if (expected_digits.size() == 0) begin
							void'(pending_items.pop_front());
							gap_count = 0;
						end
					end
				endcase
			end
		end
	end

	initial begin
		int pick;
		logic [fdss_pkg::VALUE_W-1:0] v;
		bit burst;
		foreach (DIRECTED[i]) begin
			queue_item(SHOW_VALUE, DIRECTED[i], (i < 8) ? 0 : $urandom_range(0, 19));
		end
		foreach (DOT_PLAN[p]) begin
			queue_item(SET_DOT, fdss_pkg::VALUE_W'(DOT_PLAN[p]), $urandom_range(0, 19));
			burst = (p % 3 == 1);
			for (int n = 0; n < 25; n++) begin
				if (n == 12 && p % 2 == 0) begin
					queue_item(WAIT_IDLE, '0, 0);
				end
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					v = fdss_pkg::VALUE_W'($urandom_range(0, SHOW_LIMIT - 1));
				end else if (pick == 7) begin
					v = fdss_pkg::VALUE_W'($urandom_range(0, 1) ? SHOW_LIMIT - 1 : SHOW_LIMIT);
				end else begin
					v = fdss_pkg::VALUE_W'($urandom_range(SHOW_LIMIT, 16'hFFFF));
				end
				queue_item(SHOW_VALUE, v, burst ? 0 : $urandom_range(0, 19));
			end
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait (stim_done);
		while (expected_digits.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/fdss_pkg.sv
sv/fdss_digit_cell.sv
sv/fdss_scan_out.sv
sv/four_digit_seven_segment_scan_unit.sv
test/tb_four_digit_seven_segment_scan_unit.sv
